FILE: rtl/checksum_frame_receiver_core_defines.svh
// assertion macros used by the frame receiver core
`ifndef CHECKSUM_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CHECKSUM_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// concurrent check, sampled on clk, off while rst is high
`define CFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame receiver check failed");
// concurrent check that also holds during reset
`define CFR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("frame receiver check failed");
`else
`define CFR_ASSERT(label, prop)
`define CFR_ASSERT_ALWAYS(label, prop)
`endif

`endif

FILE: rtl/cfr_pkg.sv
// types and constants of the checksum frame receiver
package cfr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned INDEX_W    = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE       = 2'd2;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    PH_HEAD     = 3'd0,
    PH_ADDRESS  = 3'd1,
    PH_COMMAND  = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_DATA     = 3'd4,
    PH_CHECKSUM = 3'd5,
    PH_END      = 3'd6
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic               store_valid;
    logic [INDEX_W-1:0] store_index;
    logic [7:0]         store_value;
    logic               frame_done;
    logic               checksum_error;
    logic               end_error;
    logic               frame_ready;
    logic [2:0]         parse_phase;
  } result_t;

endpackage

FILE: rtl/cfr_rx_if.sv
// input channel: received bytes and clear requests
interface cfr_rx_if;
  logic              valid;
  logic              ready;
  cfr_pkg::rx_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/cfr_res_if.sv
// output channel: one result per input beat
interface cfr_res_if;
  logic             valid;
  logic             ready;
  cfr_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/checksum_frame_receiver_core.sv
// flow: an accepted beat goes into the input register, then its parse result into the result register
// throughput: one beat per cycle while results are taken; one parse step sits between the input
// register and the result register, and the result register frees the input side
// every input beat gives exactly one result beat
// reset: synchronous, active high; clears parser state, ready flag, valid bits and config registers
`include "checksum_frame_receiver_core_defines.svh"

module checksum_frame_receiver_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [cfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfr_pkg::CFG_DATA_W-1:0]     cfg_data,
  cfr_rx_if.sink                             rx_chan,
  cfr_res_if.source                          res_chan
);

  logic [7:0] device_address;
  logic [7:0] head_byte;
  logic [7:0] end_byte;

  // input stage
  logic              s1_valid;
  cfr_pkg::rx_item_t s1_item;
  logic              s1_adv;

  // parser state
  cfr_pkg::phase_t                  phase, phase_next;
  logic [cfr_pkg::INDEX_W-1:0]      byte_count, byte_count_next;
  logic [7:0]                       running_sum, running_sum_next;
  logic [7:0]                       bytes_left, bytes_left_next;
  logic                             ready_flag, ready_flag_next;

  logic                             store;
  logic                             done;
  logic                             cs_err;
  logic                             end_err;
  logic [cfr_pkg::INDEX_W-1:0]      idx_base;
  cfr_pkg::result_t                 result_next;

  // result register
  logic             res_valid;
  cfr_pkg::result_t res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= '0;
      head_byte      <= '0;
      end_byte       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cfr_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data;
        cfr_pkg::CFG_HEAD_BYTE:      head_byte      <= cfg_data;
        cfr_pkg::CFG_END_BYTE:       end_byte       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv        = s1_valid && (!res_valid || res_chan.ready);
  assign rx_chan.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_chan.ready) begin
      s1_valid <= rx_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_chan.ready && rx_chan.valid) begin
      s1_item <= rx_chan.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cfr_pkg::PH_HEAD;
      byte_count  <= '0;
      running_sum <= '0;
      bytes_left  <= '0;
      ready_flag  <= 1'b0;
    end else if (s1_adv) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      bytes_left  <= bytes_left_next;
      ready_flag  <= ready_flag_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    bytes_left_next  = bytes_left;
    ready_flag_next  = ready_flag;
    idx_base         = byte_count;
    store            = 1'b0;
    done             = 1'b0;
    cs_err           = 1'b0;
    end_err          = 1'b0;
    if (s1_item.kind == cfr_pkg::KIND_CLEAR) begin
      ready_flag_next = 1'b0;
    end else if (!ready_flag) begin
      unique case (phase)
        cfr_pkg::PH_HEAD: begin
          if (s1_item.rx_byte == head_byte) begin
            running_sum_next = s1_item.rx_byte;
            idx_base         = '0;
            store            = 1'b1;
            phase_next       = cfr_pkg::PH_ADDRESS;
          end
        end
        cfr_pkg::PH_ADDRESS: begin
          if (s1_item.rx_byte == device_address) begin
            running_sum_next = 8'(running_sum + s1_item.rx_byte);
            store            = 1'b1;
            phase_next       = cfr_pkg::PH_COMMAND;
          end
        end
        cfr_pkg::PH_COMMAND: begin
          running_sum_next = 8'(running_sum + s1_item.rx_byte);
          store            = 1'b1;
          phase_next       = cfr_pkg::PH_LENGTH;
        end
        cfr_pkg::PH_LENGTH: begin
          running_sum_next = 8'(running_sum + s1_item.rx_byte);
          bytes_left_next  = s1_item.rx_byte;
          store            = 1'b1;
          // zero length goes straight to the checksum
          phase_next       = (s1_item.rx_byte == 8'd0) ? cfr_pkg::PH_CHECKSUM
                                                       : cfr_pkg::PH_DATA;
        end
        cfr_pkg::PH_DATA: begin
          running_sum_next = 8'(running_sum + s1_item.rx_byte);
          store            = 1'b1;
          if (bytes_left <= 8'd1) begin
            bytes_left_next = '0;
            phase_next      = cfr_pkg::PH_CHECKSUM;
          end else begin
            bytes_left_next = 8'(bytes_left - 8'd1);
          end
        end
        cfr_pkg::PH_CHECKSUM: begin
          store = 1'b1;
          if (s1_item.rx_byte != running_sum) begin
            cs_err     = 1'b1;
            phase_next = cfr_pkg::PH_HEAD;
          end else begin
            phase_next = cfr_pkg::PH_END;
          end
        end
        cfr_pkg::PH_END: begin
          store = 1'b1;
          if (s1_item.rx_byte == end_byte) begin
            ready_flag_next = 1'b1;
            done            = 1'b1;
          end else begin
            end_err = 1'b1;
          end
          phase_next = cfr_pkg::PH_HEAD;
        end
        default: begin
          phase_next = cfr_pkg::PH_HEAD;
        end
      endcase
    end

    // index saturates at all ones
    if (store && (idx_base != '1)) begin
      byte_count_next = idx_base + {{(cfr_pkg::INDEX_W-1){1'b0}}, 1'b1};
    end else if (store) begin
      byte_count_next = idx_base;
    end else begin
      byte_count_next = byte_count;
    end

    result_next.store_valid    = store;
    result_next.store_index    = store ? idx_base : '0;
    result_next.store_value    = store ? s1_item.rx_byte : '0;
    result_next.frame_done     = done;
    result_next.checksum_error = cs_err;
    result_next.end_error      = end_err;
    result_next.frame_ready    = ready_flag_next;
    result_next.parse_phase    = 3'(phase_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (res_chan.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_data <= result_next;
    end
  end

  assign res_chan.valid = res_valid;
  assign res_chan.data  = res_data;

  // input side stalls only while both stages are full and the result waits
  `CFR_ASSERT(a_stall_cause, !rx_chan.ready |-> (s1_valid && res_valid && !res_chan.ready))
  // a byte seen while a frame awaits software never reaches the buffer
  `CFR_ASSERT(a_ready_blocks_store,
    (s1_adv && (s1_item.kind == cfr_pkg::KIND_BYTE) && ready_flag) |=> !res_data.store_valid)
  // a clear request always drops the ready flag
  `CFR_ASSERT(a_clear_drops_flag,
    (s1_adv && (s1_item.kind == cfr_pkg::KIND_CLEAR)) |=> !ready_flag)
  // parser state moves only when a beat advances
  `CFR_ASSERT(a_phase_holds, !s1_adv |=> ($stable(phase) && $stable(ready_flag)))
  // at most one of done and the two error pulses per result
  `CFR_ASSERT_ALWAYS(a_one_outcome,
    res_valid |-> $onehot0({res_data.frame_done, res_data.checksum_error, res_data.end_error}))

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the checksum frame receiver: directed table, then random frames
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [cfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] DIR_ADDR = 8'h5A;
  localparam logic [7:0] DIR_HEAD = 8'hAA;
  localparam logic [7:0] DIR_END  = 8'h55;

  typedef enum int {FAULT_NONE, FAULT_ADDR, FAULT_SUM, FAULT_END, FAULT_CUT} frame_fault_t;

  typedef struct {
    cfr_pkg::rx_item_t item;
    bit                typed;
    cfr_pkg::result_t  want;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cfr_pkg::CFG_DATA_W-1:0] cfg_data;

  cfr_rx_if  rx_chan ();
  cfr_res_if res_chan ();

  checksum_frame_receiver_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_chan   (rx_chan),
    .res_chan  (res_chan)
  );

  // mirror of the receiver: registers and parser state
  logic [7:0]      cfg_addr;
  logic [7:0]      cfg_head;
  logic [7:0]      cfg_end;
  cfr_pkg::phase_t ph;
  logic [8:0]      count;
  logic [7:0]      sum;
  logic [7:0]      left;
  logic            rdy_flag;

  cfr_pkg::result_t pending_results[$];
  bit               drv_typed;
  cfr_pkg::result_t drv_want;
  bit               quiet;
  int unsigned      mismatches;
  int unsigned      beats_sent;
  int unsigned      cycles;
  cfr_pkg::result_t got;
  cfr_pkg::result_t want;
  cfr_pkg::result_t predicted;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cfr_pkg::result_t mk_result(logic sv, logic [8:0] idx, logic [7:0] val,
                                                 logic done, logic cs, logic ee, logic rdy,
                                                 cfr_pkg::phase_t p);
    cfr_pkg::result_t r;
    r.store_valid    = sv;
    r.store_index    = idx;
    r.store_value    = val;
    r.frame_done     = done;
    r.checksum_error = cs;
    r.end_error      = ee;
    r.frame_ready    = rdy;
    r.parse_phase    = p;
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic kind, logic [7:0] b, bit typed,
                                       cfr_pkg::result_t w);
    stim_row_t s;
    s.item.kind    = kind;
    s.item.rx_byte = b;
    s.typed        = typed;
    s.want         = w;
    return s;
  endfunction

  // one parse step on the mirror state
  function automatic cfr_pkg::result_t frame_step(cfr_pkg::rx_item_t it);
    cfr_pkg::result_t r;
    logic             store;
    logic [7:0]       b;
    r     = '0;
    store = 1'b0;
    b     = it.rx_byte;
    if (it.kind == cfr_pkg::KIND_CLEAR) begin
      rdy_flag = 1'b0;
    end else if (!rdy_flag) begin
      case (ph)
        cfr_pkg::PH_HEAD: begin
          if (b == cfg_head) begin
            sum   = b;
            count = '0;
            store = 1'b1;
            ph    = cfr_pkg::PH_ADDRESS;
          end
        end
        cfr_pkg::PH_ADDRESS: begin
          if (b == cfg_addr) begin
            sum   = sum + b;
            store = 1'b1;
            ph    = cfr_pkg::PH_COMMAND;
          end
        end
        cfr_pkg::PH_COMMAND: begin
          sum   = sum + b;
          store = 1'b1;
          ph    = cfr_pkg::PH_LENGTH;
        end
        cfr_pkg::PH_LENGTH: begin
          sum   = sum + b;
          left  = b;
          store = 1'b1;
          ph    = (b == 8'd0) ? cfr_pkg::PH_CHECKSUM : cfr_pkg::PH_DATA;
        end
        cfr_pkg::PH_DATA: begin
          sum   = sum + b;
          store = 1'b1;
          if (left <= 8'd1) begin
            left = '0;
            ph   = cfr_pkg::PH_CHECKSUM;
          end else begin
            left = left - 8'd1;
          end
        end
        cfr_pkg::PH_CHECKSUM: begin
          store = 1'b1;
          if (b != sum) begin
            r.checksum_error = 1'b1;
            ph               = cfr_pkg::PH_HEAD;
          end else begin
            ph = cfr_pkg::PH_END;
          end
        end
        cfr_pkg::PH_END: begin
          store = 1'b1;
          if (b == cfg_end) begin
            rdy_flag     = 1'b1;
            r.frame_done = 1'b1;
          end else begin
            r.end_error = 1'b1;
          end
          ph = cfr_pkg::PH_HEAD;
        end
        default: ph = cfr_pkg::PH_HEAD;
      endcase
      if (store) begin
        r.store_valid = 1'b1;
        r.store_index = count;
        r.store_value = b;
        if (count != 9'h1FF) count = count + 9'd1;
      end
    end
    r.frame_ready = rdy_flag;
    r.parse_phase = ph;
    return r;
  endfunction

  // most gaps short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // checks result beats, predicts input beats, tracks register writes
  always @(posedge clk) begin
    if (rst) begin
      cfg_addr = '0;
      cfg_head = '0;
      cfg_end  = '0;
      ph       = cfr_pkg::PH_HEAD;
      count    = '0;
      sum      = '0;
      left     = '0;
      rdy_flag = 1'b0;
    end else begin
      if (res_chan.valid && res_chan.ready) begin
        got = res_chan.data;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("error: result beat with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: exp st=%0b idx=%0d val=%h done=%0b cs=%0b ee=%0b rdy=%0b ph=%0d",
                     want.store_valid, want.store_index, want.store_value, want.frame_done,
                     want.checksum_error, want.end_error, want.frame_ready, want.parse_phase);
              $display(" | got st=%0b idx=%0d val=%h done=%0b cs=%0b ee=%0b rdy=%0b ph=%0d",
                       got.store_valid, got.store_index, got.store_value, got.frame_done,
                       got.checksum_error, got.end_error, got.frame_ready, got.parse_phase);
            end
          end
        end
      end
      if (rx_chan.valid && rx_chan.ready) begin
        predicted = frame_step(rx_chan.data);
        pending_results.push_back(drv_typed ? drv_want : predicted);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          cfr_pkg::CFG_DEVICE_ADDRESS: cfg_addr = cfg_data;
          cfr_pkg::CFG_HEAD_BYTE:      cfg_head = cfg_data;
          cfr_pkg::CFG_END_BYTE:       cfg_end  = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result sink with random stalls
  initial begin
    int unsigned stall;
    stall          = 0;
    res_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_chan.ready <= 1'b0;
      end else if (stall > 0) begin
        res_chan.ready <= 1'b0;
        stall--;
      end else begin
        res_chan.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall = pick_gap();
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL checksum_frame_receiver_core");
    $finish;
  end

  task automatic send_item(logic kind, logic [7:0] b, bit typed = 1'b0,
                           cfr_pkg::result_t w = '0);
    int unsigned       g;
    cfr_pkg::rx_item_t it;
    g          = pick_gap();
    it.kind    = kind;
    it.rx_byte = b;
    if (g > 0) begin
      @(negedge clk);
      rx_chan.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_chan.valid <= 1'b1;
    rx_chan.data  <= it;
    drv_typed     <= typed;
    drv_want      <= w;
    do @(posedge clk); while (!rx_chan.ready);
    beats_sent++;
  endtask

  // hold the sender until every result is back
  task automatic drain();
    @(negedge clk);
    rx_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [cfr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] a, logic [7:0] h, logic [7:0] e);
    drain();
    write_reg(cfr_pkg::CFG_DEVICE_ADDRESS, a);
    write_reg(cfr_pkg::CFG_HEAD_BYTE, h);
    write_reg(cfr_pkg::CFG_END_BYTE, e);
    // index with no register behind it must not disturb anything
    if ($urandom_range(0, 1) == 1) write_reg(CFG_UNUSED, 8'($urandom));
  endtask

  task automatic send_frame(frame_fault_t fault, int unsigned len);
    logic [7:0]  bytes[$];
    logic [7:0]  s;
    logic [7:0]  v;
    int unsigned cut;
    bytes.push_back(cfg_head);
    if (fault == FAULT_ADDR) bytes.push_back(cfg_addr ^ 8'($urandom_range(1, 255)));
    bytes.push_back(cfg_addr);
    s = cfg_head + cfg_addr;
    v = 8'($urandom);
    bytes.push_back(v);
    s = s + v;
    bytes.push_back(8'(len));
    s = s + 8'(len);
    repeat (len) begin
      v = 8'($urandom);
      bytes.push_back(v);
      s = s + v;
    end
    bytes.push_back(fault == FAULT_SUM ? s + 8'($urandom_range(1, 255)) : s);
    bytes.push_back(fault == FAULT_END ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
    cut = (fault == FAULT_CUT) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(0, 99) < 3) send_item(cfr_pkg::KIND_CLEAR, 8'($urandom));
      send_item(cfr_pkg::KIND_BYTE, bytes[i]);
    end
    if (fault == FAULT_NONE) begin
      // bytes while the frame waits for software, then usually the clear
      repeat ($urandom_range(0, 2)) send_item(cfr_pkg::KIND_BYTE, 8'($urandom));
      if ($urandom_range(0, 99) < 85) send_item(cfr_pkg::KIND_CLEAR, 8'($urandom));
    end
  endtask

  task automatic run_random(int unsigned budget);
    int unsigned  start;
    int unsigned  r;
    int unsigned  len;
    frame_fault_t f;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 24);
        r   = $urandom_range(0, 99);
        if (r < 60)      f = FAULT_NONE;
        else if (r < 70) f = FAULT_ADDR;
        else if (r < 80) f = FAULT_SUM;
        else if (r < 90) f = FAULT_END;
        else             f = FAULT_CUT;
        send_frame(f, len);
      end else if (r < 88) begin
        repeat ($urandom_range(1, 4)) send_item(cfr_pkg::KIND_BYTE, 8'($urandom));
      end else begin
        send_item(cfr_pkg::KIND_CLEAR, 8'($urandom));
      end
    end
  endtask

  initial begin
    stim_row_t rows[$];
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    rx_chan.valid = 1'b0;
    rx_chan.data  = '0;
    drv_typed     = 1'b0;
    drv_want      = '0;
    quiet         = 1'b0;
    mismatches    = 0;
    beats_sent    = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    set_config(DIR_ADDR, DIR_HEAD, DIR_END);
    // clear while idle, noise, then a zero-length frame that completes
    rows.push_back(mk_row(cfr_pkg::KIND_CLEAR, 8'h00, 1,
                          mk_result(0, 0, 0, 0, 0, 0, 0, cfr_pkg::PH_HEAD)));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'hFF, 1,
                          mk_result(0, 0, 0, 0, 0, 0, 0, cfr_pkg::PH_HEAD)));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, DIR_HEAD, 1,
                          mk_result(1, 0, DIR_HEAD, 0, 0, 0, 0, cfr_pkg::PH_ADDRESS)));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h00, 1,
                          mk_result(0, 0, 0, 0, 0, 0, 0, cfr_pkg::PH_ADDRESS)));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, DIR_ADDR, 1,
                          mk_result(1, 1, DIR_ADDR, 0, 0, 0, 0, cfr_pkg::PH_COMMAND)));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'hFF, 1,
                          mk_result(1, 2, 8'hFF, 0, 0, 0, 0, cfr_pkg::PH_LENGTH)));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h00, 1,
                          mk_result(1, 3, 8'h00, 0, 0, 0, 0, cfr_pkg::PH_CHECKSUM)));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h03, 1,
                          mk_result(1, 4, 8'h03, 0, 0, 0, 0, cfr_pkg::PH_END)));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, DIR_END, 1,
                          mk_result(1, 5, DIR_END, 1, 0, 0, 1, cfr_pkg::PH_HEAD)));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, DIR_HEAD, 1,
                          mk_result(0, 0, 0, 0, 0, 0, 1, cfr_pkg::PH_HEAD)));
    rows.push_back(mk_row(cfr_pkg::KIND_CLEAR, 8'hFF, 1,
                          mk_result(0, 0, 0, 0, 0, 0, 0, cfr_pkg::PH_HEAD)));
    // two data bytes, clear in mid frame, bad checksum
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, DIR_HEAD, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, DIR_ADDR, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_CLEAR, 8'h00, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h01, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h02, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h80, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h7F, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h00, 1,
                          mk_result(1, 6, 8'h00, 0, 1, 0, 0, cfr_pkg::PH_HEAD)));
    // good checksum, wrong closing byte
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, DIR_HEAD, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, DIR_ADDR, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h00, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h00, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h04, 0, '0));
    rows.push_back(mk_row(cfr_pkg::KIND_BYTE, 8'h00, 1,
                          mk_result(1, 5, 8'h00, 0, 0, 1, 0, cfr_pkg::PH_HEAD)));
    foreach (rows[i]) send_item(rows[i].item.kind, rows[i].item.rx_byte, rows[i].typed,
                                rows[i].want);

    set_config(8'h00, 8'hFF, 8'h00);
    run_random(70);
    set_config(8'hFF, 8'h00, 8'hFF);
    quiet = 1'b1;
    run_random(70);
    set_config(8'($urandom), 8'($urandom), 8'($urandom));
    quiet = 1'b0;
    run_random(70);
    // longest frame: length 255, the index climbs to 260 at the closing byte
    set_config(8'($urandom), 8'($urandom), 8'($urandom));
    send_frame(FAULT_NONE, 255);
    run_random(20);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS checksum_frame_receiver_core");
    end else begin
      $display("FAIL checksum_frame_receiver_core");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cfr_pkg.sv
rtl/cfr_rx_if.sv
rtl/cfr_res_if.sv
rtl/checksum_frame_receiver_core.sv
verif/tb_top.sv
